// ===== hdl/wl2rgb_pkg.sv =====
// Package for the wavelength to RGB mapper: widths, band tables, band select.
// Used by wl2rgb_poly, wl2rgb_div and wavelength_to_rgb. No dependencies.
package wl2rgb_pkg;

  localparam int WlW               = 14;  // wavelength, 1/16 nm
  localparam int LevelW            = 16;  // output level width
  localparam int LevelFracBitsDef  = 16;  // default fraction bits of a level
  localparam int DW                = 11;  // offset into a band, below 2048
  localparam int SqW               = 22;  // d*S and d*d
  localparam int TermW             = 32;  // signed coefficient terms
  localparam int SumW              = 34;  // signed quadratic sum
  localparam int NW                = 33;  // positive numerator
  localparam int DenW              = 29;  // 100*S*S, below 2^29
  localparam int BandsMax          = 5;
  localparam int FrontStages       = 5;   // input, select, three poly stages

  // no channel has a band outside this window
  localparam logic [WlW-1:0] VisibleLo = 14'd6400;   // 400 nm
  localparam logic [WlW-1:0] VisibleHi = 14'd11200;  // 700 nm

  typedef enum logic [1:0] {
    ChRed   = 2'd0,
    ChGreen = 2'd1,
    ChBlue  = 2'd2
  } chan_e;

  // one band: start and span in 1/16 nm, coefficients in hundredths,
  // c0 = k0*S*S and den = 100*S*S precomputed
  typedef struct packed {
    logic        [WlW-1:0]   lo;
    logic        [DW-1:0]    span;
    logic signed [8:0]       k1;
    logic signed [8:0]       k2;
    logic signed [TermW-1:0] c0;
    logic        [DenW-1:0]  den;
  } band_t;

  // selected band and offset of the wavelength into it
  typedef struct packed {
    logic          hit;
    logic [DW-1:0] d;
    band_t         band;
  } sel_t;

  // polynomial result handed to the divider
  typedef struct packed {
    logic            pos;
    logic [NW-1:0]   n;
    logic [DenW-1:0] den;
  } poly_t;

  function automatic int band_count(chan_e ch);
    int cnt;
    unique case (ch)
      ChRed:   cnt = 5;
      ChGreen: cnt = 3;
      ChBlue:  cnt = 2;
      default: cnt = 0;
    endcase
    return cnt;
  endfunction

  function automatic band_t mk_band(int lo, int span, int k1, int k2, int c0, int den);
    band_t b;
    b.lo   = WlW'(lo);
    b.span = DW'(span);
    b.k1   = 9'(k1);
    b.k2   = 9'(k2);
    b.c0   = TermW'(c0);
    b.den  = DenW'(den);
    return b;
  endfunction

  // band table, in priority order within each channel
  function automatic band_t band_get(chan_e ch, logic [2:0] idx);
    band_t b;
    b = '0;
    unique case (ch)
      ChRed: begin
        unique case (idx)
          3'd0:    b = mk_band( 6400,  160,   33,  -20,          0,   2560000);
          3'd1:    b = mk_band( 6560, 1040,    0,  -13,   15142400, 108160000);
          3'd2:    b = mk_band( 8720,  800,  198, -100,          0,  64000000);
          3'd3:    b = mk_band( 9520,  880,    6,  -40,   75891200,  77440000);
          3'd4:    b = mk_band(10400,  800,  -84,   20,   41600000,  64000000);
          default: b = '0;
        endcase
      end
      ChGreen: begin
        unique case (idx)
          3'd0:    b = mk_band( 6640,  960,    0,   80,          0,  92160000);
          3'd1:    b = mk_band( 7600, 1840,   76,  -80,  270848000, 338560000);
          3'd2:    b = mk_band( 9360,  864,  -84,    0,   62705664,  74649600);
          default: b = '0;
        endcase
      end
      ChBlue: begin
        unique case (idx)
          3'd0:    b = mk_band( 6400, 1200,  220, -150,          0, 144000000);
          3'd1:    b = mk_band( 7600, 1360, -100,   30,  129472000, 184960000);
          default: b = '0;
        endcase
      end
      default: b = '0;
    endcase
    return b;
  endfunction

  // first band in list order that holds w; scanned from the back so the
  // earliest hit is the one left standing
  function automatic sel_t band_select(chan_e ch, logic [WlW-1:0] w);
    sel_t           s;
    band_t          b;
    logic [WlW:0]   hi;
    s = '0;
    for (int i = BandsMax - 1; i >= 0; i--) begin
      if (i < band_count(ch)) begin
        b  = band_get(ch, 3'(i));
        hi = {1'b0, b.lo} + (WlW + 1)'(b.span);
        if (w >= b.lo && {1'b0, w} < hi) begin
          s.hit  = 1'b1;
          s.d    = DW'(w - b.lo);
          s.band = b;
        end
      end
    end
    return s;
  endfunction

  // integer bits of a level: the fraction width, capped by the port width
  function automatic int level_bits(int f);
    return (f < LevelW) ? f : LevelW;
  endfunction

endpackage

// ===== hdl/wl2rgb_poly.sv =====
// Three-stage quadratic evaluator for one channel: n = k0*S*S + k1*d*S + k2*d*d.
// Depends on wl2rgb_pkg (sel_t, poly_t, widths).
module wl2rgb_poly
  import wl2rgb_pkg::*;
(
  input  logic  clk_i,
  input  sel_t  sel_i,
  output poly_t poly_o
);

  // stage A: the two 11x11 products
  logic [SqW-1:0] ds_q, dd_q;
  band_t          band_a_q;
  logic           hit_a_q;

  always_ff @(posedge clk_i) begin
    ds_q     <= SqW'(sel_i.d) * SqW'(sel_i.band.span);
    dd_q     <= SqW'(sel_i.d) * SqW'(sel_i.d);
    band_a_q <= sel_i.band;
    hit_a_q  <= sel_i.hit;
  end

  // stage B: scale by the signed coefficients
  logic signed [TermW-1:0] k1x, k2x, dsx, ddx;
  logic signed [TermW-1:0] t1_q, t2_q, c0_q;
  logic        [DenW-1:0]  den_b_q;
  logic                    hit_b_q;

  assign k1x = {{(TermW - 9){band_a_q.k1[8]}}, band_a_q.k1};
  assign k2x = {{(TermW - 9){band_a_q.k2[8]}}, band_a_q.k2};
  assign dsx = {{(TermW - SqW){1'b0}}, ds_q};
  assign ddx = {{(TermW - SqW){1'b0}}, dd_q};

  always_ff @(posedge clk_i) begin
    t1_q    <= k1x * dsx;
    t2_q    <= k2x * ddx;
    c0_q    <= band_a_q.c0;
    den_b_q <= band_a_q.den;
    hit_b_q <= hit_a_q;
  end

  // stage C: sum; nonpositive or missed band gives a zero level
  logic signed [SumW-1:0] sum;
  poly_t                  poly_d, poly_q;

  always_comb begin
    sum = {{(SumW - TermW){c0_q[TermW-1]}}, c0_q}
        + {{(SumW - TermW){t1_q[TermW-1]}}, t1_q}
        + {{(SumW - TermW){t2_q[TermW-1]}}, t2_q};
    poly_d.pos = hit_b_q && !sum[SumW-1] && (sum != '0);
    poly_d.n   = poly_d.pos ? sum[NW-1:0] : '0;
    poly_d.den = den_b_q;
  end

  always_ff @(posedge clk_i) begin
    poly_q <= poly_d;
  end

  assign poly_o = poly_q;

endmodule

// ===== hdl/wl2rgb_div.sv =====
// Pipelined restoring divider with rounding and clamp: level = round(n*2^F / den).
// One quotient bit per stage. Depends on wl2rgb_pkg (poly_t, widths, level_bits).
module wl2rgb_div
  import wl2rgb_pkg::*;
#(
  parameter int LEVEL_FRAC_BITS = LevelFracBitsDef
) (
  input  logic              clk_i,
  input  poly_t             poly_i,
  output logic [LevelW-1:0] level_o
);

  // QB quotient bits of n*2^(F+1)/den; the extra low bit does the rounding
  localparam int LB = level_bits(LEVEL_FRAC_BITS);
  localparam int QB = LB + 1;
  localparam int SH = LEVEL_FRAC_BITS - LB;
  localparam int RW = NW + SH;
  localparam logic [LB-1:0] Top = {LB{1'b1}};

  logic [DenW-1:0] rem_q [QB+1];
  logic [QB-1:0]   quo_q [QB+1];
  logic [DenW-1:0] den_q [QB+1];
  logic            pos_q [QB+1];
  logic            ovf_q [QB+1];

  // entry: leading remainder, overflow when the quotient would not fit QB bits
  logic [RW-1:0] r0;
  logic          ovf0;

  assign r0   = RW'(poly_i.n) << SH;
  assign ovf0 = r0 >= RW'(poly_i.den);

  // one compare-subtract per stage
  logic [DenW:0]   dbl   [QB];
  logic            ge    [QB];
  logic [DenW-1:0] rem_d [QB];
  logic [QB-1:0]   quo_d [QB];

  always_comb begin
    for (int s = 0; s < QB; s++) begin
      dbl[s]   = {rem_q[s], 1'b0};
      ge[s]    = dbl[s] >= {1'b0, den_q[s]};
      rem_d[s] = ge[s] ? DenW'(dbl[s] - {1'b0, den_q[s]}) : dbl[s][DenW-1:0];
      quo_d[s] = {quo_q[s][QB-2:0], ge[s]};
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0] <= r0[DenW-1:0];
    quo_q[0] <= '0;
    den_q[0] <= poly_i.den;
    pos_q[0] <= poly_i.pos;
    ovf_q[0] <= ovf0;
    for (int s = 0; s < QB; s++) begin
      rem_q[s+1] <= rem_d[s];
      quo_q[s+1] <= quo_d[s];
      den_q[s+1] <= den_q[s];
      pos_q[s+1] <= pos_q[s];
      ovf_q[s+1] <= ovf_q[s];
    end
  end

  // round half up, then clamp to the top level
  logic [QB:0]       qsum;
  logic [QB-1:0]     qr;
  logic [LB-1:0]     lvl;
  logic [LevelW-1:0] level_q;

  always_comb begin
    qsum = {1'b0, quo_q[QB]} + (QB + 1)'(1);
    qr   = qsum[QB:1];
    if (!pos_q[QB]) begin
      lvl = '0;
    end else if (ovf_q[QB] || qr[QB-1]) begin
      lvl = Top;
    end else begin
      lvl = qr[LB-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    level_q <= LevelW'(lvl);
  end

  assign level_o = level_q;

endmodule

// ===== hdl/wavelength_to_rgb.sv =====
// Top level of the wavelength to RGB mapper: input register, band select,
// valid chain, one wl2rgb_poly and one wl2rgb_div per color channel.
// Depends on wl2rgb_pkg, wl2rgb_poly, wl2rgb_div.
//
//  channel  | ports                                   | beat taken when
//  ---------+-----------------------------------------+--------------------
//  command  | start_i, busy_o, wavelength_i           | start_i && !busy_o
//  result   | done_o, red/green/blue_level_o          | done_o (one cycle)
//
// A beat can enter every cycle; busy_o stays low. The pipeline has two
// front stages, three for the quadratic, and one divider stage per quotient
// bit plus entry and output registers. Reset clears only the valid chain;
// results of beats in flight at reset are dropped. The receiver cannot stall,
// so nothing waits.
module wavelength_to_rgb
  import wl2rgb_pkg::*;
#(
  parameter int LEVEL_FRAC_BITS = LevelFracBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [WlW-1:0]    wavelength_i,
  output logic              done_o,
  output logic [LevelW-1:0] red_level_o,
  output logic [LevelW-1:0] green_level_o,
  output logic [LevelW-1:0] blue_level_o
);

  localparam int Lat = FrontStages + level_bits(LEVEL_FRAC_BITS) + 3;

  logic accept;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // valid chain, in step with the data pipeline
  logic [Lat-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Lat-2:0], accept};
    end
  end

  assign done_o = vld_q[Lat-1];

  // input register
  logic [WlW-1:0] wl_q;

  always_ff @(posedge clk_i) begin
    wl_q <= wavelength_i;
  end

  // per channel: band select, quadratic, divide
  logic [LevelW-1:0] level [3];

  for (genvar c = 0; c < 3; c++) begin : g_chan
    sel_t  sel_q;
    poly_t poly;

    always_ff @(posedge clk_i) begin
      sel_q <= band_select(chan_e'(c), wl_q);
    end

    wl2rgb_poly u_poly (
      .clk_i  (clk_i),
      .sel_i  (sel_q),
      .poly_o (poly)
    );

    wl2rgb_div #(
      .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
    ) u_div (
      .clk_i   (clk_i),
      .poly_i  (poly),
      .level_o (level[c])
    );
  end

  assign red_level_o   = level[ChRed];
  assign green_level_o = level[ChGreen];
  assign blue_level_o  = level[ChBlue];

  // every accepted beat comes out as a done_o pulse
  a_beat_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##Lat done_o)
    else $error("accepted beat did not produce a result");

  // no result without an accepted beat
  a_no_ghost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, Lat))
    else $error("result without a matching beat");

  // wavelengths outside the visible window give black
  a_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && ($past(wavelength_i, Lat) < VisibleLo ||
                $past(wavelength_i, Lat) >= VisibleHi))
    |-> (red_level_o == '0 && green_level_o == '0 && blue_level_o == '0))
    else $error("nonzero level outside the visible window");

endmodule
